/* rtl/smma_pkg.sv */
// Shared types and request codes for the sparse matrix merge adder.
`default_nettype none

package smma_pkg;

    // Request kinds on the input channel
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_MERGE  = 2'd2;

    // One stored coordinate entry; {col, row} is the sort key
    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [31:0] value;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

`default_nettype wire

/* rtl/smma_mem.sv */
// Single-port-write, single-port-read entry memory with registered read data.
`default_nettype none

module smma_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire                 clk,
    input  wire                 we,
    input  wire [AW-1:0]        waddr,
    input  wire smma_pkg::entry_t wdata,
    input  wire [AW-1:0]        raddr,
    output smma_pkg::entry_t    rdata
);
    import smma_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/smma_core.sv */
// Load control, merge walk, pending result holder and output register.
`default_nettype none

module smma_core #(
    parameter int MAX_TERMS = 32,
    parameter int AW        = 5,
    parameter int CW        = 6
) (
    input  wire                 clk,
    input  wire                 rst_n,
    // input channel
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire [1:0]           kind,
    input  wire [15:0]          col,
    input  wire [15:0]          row,
    input  wire signed [31:0]   value,
    // output channel
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [15:0]         col_res,
    output logic [15:0]         row_res,
    output logic signed [31:0]  value_res,
    output logic                last,
    output logic                empty_res,
    output logic                overflow,
    // list memories
    output logic                we_a,
    output logic                we_b,
    output logic [AW-1:0]       waddr_a,
    output logic [AW-1:0]       waddr_b,
    output smma_pkg::entry_t    wdata,
    output logic [AW-1:0]       raddr_a,
    output logic [AW-1:0]       raddr_b,
    input  wire smma_pkg::entry_t rdata_a,
    input  wire smma_pkg::entry_t rdata_b
);
    import smma_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_a_reg, count_a_next;
    logic [CW-1:0]  count_b_reg, count_b_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic           ovf_reg, ovf_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [31:0]    pend_key_reg, pend_key_next;
    logic [31:0]    pend_val_reg, pend_val_next;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_key_reg, out_key_next;
    logic [31:0]    out_val_reg, out_val_next;
    logic           out_last_reg, out_last_next;
    logic           out_empty_reg, out_empty_next;
    logic           out_ovf_reg, out_ovf_next;

    logic           a_has, b_has, done, take_a, take_b, out_free;
    logic [31:0]    key_a, key_b, cand_key, cand_val;

    // Head compare and sum of the two list entries
    always_comb
    begin
        a_has  = i_reg < count_a_reg;
        b_has  = j_reg < count_b_reg;
        done   = !a_has && !b_has;
        key_a  = {rdata_a.col, rdata_a.row};
        key_b  = {rdata_b.col, rdata_b.row};
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_has && b_has)
        begin
            if (key_a == key_b)
            begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
            else if (key_a < key_b)
            begin
                take_a = 1'b1;
            end
            else
            begin
                take_b = 1'b1;
            end
        end
        else if (a_has)
        begin
            take_a = 1'b1;
        end
        else if (b_has)
        begin
            take_b = 1'b1;
        end
        cand_key = take_a ? key_a : key_b;
        cand_val = (take_a ? rdata_a.value : 32'd0) + (take_b ? rdata_b.value : 32'd0);
    end

    // Next state, loads and merge steps
    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_val_next   = pend_val_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        we_a            = 1'b0;
        we_b            = 1'b0;
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        KIND_LOAD_A:
                        begin
                            if (count_a_reg < FULL)
                            begin
                                we_a         = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_LOAD_B:
                        begin
                            if (count_b_reg < FULL)
                            begin
                                we_b         = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_MERGE:
                        begin
                            state_next = ST_MERGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    if (done)
                    begin
                        // final result: held entry or the empty marker
                        out_valid_next  = 1'b1;
                        out_key_next    = pend_valid_reg ? pend_key_reg : 32'd0;
                        out_val_next    = pend_valid_reg ? pend_val_reg : 32'd0;
                        out_last_next   = 1'b1;
                        out_empty_next  = !pend_valid_reg;
                        out_ovf_next    = ovf_reg;
                        pend_valid_next = 1'b0;
                        count_a_next    = '0;
                        count_b_next    = '0;
                        i_next          = '0;
                        j_next          = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(take_a);
                        j_next = j_reg + CW'(take_b);
                        // a nonzero sum pushes the held entry out and takes its place
                        if (cand_val != 32'd0)
                        begin
                            pend_valid_next = 1'b1;
                            pend_key_next   = cand_key;
                            pend_val_next   = cand_val;
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_key_next   = pend_key_reg;
                                out_val_next   = pend_val_reg;
                                out_last_next  = 1'b0;
                                out_empty_next = 1'b0;
                                out_ovf_next   = ovf_reg;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_key_reg  <= pend_key_next;
        pend_val_reg  <= pend_val_next;
        out_key_reg   <= out_key_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Memory ports: read address follows the next walk index
    assign waddr_a   = count_a_reg[AW-1:0];
    assign waddr_b   = count_b_reg[AW-1:0];
    assign wdata     = '{col: col, row: row, value: value};
    assign raddr_a   = i_next[AW-1:0];
    assign raddr_b   = j_next[AW-1:0];

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign col_res   = out_key_reg[31:16];
    assign row_res   = out_key_reg[15:0];
    assign value_res = out_val_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;
    assign overflow  = out_ovf_reg;

`ifndef SYNTH
    a_count_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= FULL) else $error("list A count beyond capacity");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (i_reg <= count_a_reg) && (j_reg <= count_b_reg))
        else $error("merge index ran past list end");
    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!we_a || count_a_reg < FULL) && (!we_b || count_b_reg < FULL))
        else $error("write into a full list");
    a_merge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE && done && out_free)
        |=> (count_a_reg == '0 && count_b_reg == '0 && !ovf_reg && !pend_valid_reg))
        else $error("merge end did not clear lists");
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && out_val_reg == 32'd0))
        else $error("empty marker not final or nonzero");
`endif

endmodule

`default_nettype wire

/* rtl/sparse_matrix_merge_add.sv */
// Top level of the sparse matrix merge adder: list memories and merge core.
//
//   channel   signals                               direction
//   in        in_valid/in_stall, kind,col,row,value  request into block
//   out       out_valid/out_stall, col_res,row_res,   result out of block
//             value_res,last,empty_res,overflow
//
// A load request writes one entry memory; a load into a full list only sets overflow.
// A merge accepts the request (both list heads are read as it is accepted),
// takes one step of the walk over both list memories per merged key, and then
// gives the final result, each step only while the output register is free;
// output stalls hold the walk.
// Reset clears counts, overflow and control state; list contents are not
// cleared and are only read below the counts.
// Input stall is high for the whole merge.
`default_nettype none

module sparse_matrix_merge_add #(
    parameter int MAX_TERMS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire [1:0]           kind,
    input  wire [15:0]          col,
    input  wire [15:0]          row,
    input  wire signed [31:0]   value,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [15:0]         col_res,
    output logic [15:0]         row_res,
    output logic signed [31:0]  value_res,
    output logic                last,
    output logic                empty_res,
    output logic                overflow
);
    import smma_pkg::*;

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    logic           we_a, we_b;
    logic [AW-1:0]  waddr_a, waddr_b, raddr_a, raddr_b;
    entry_t         wdata, rdata_a, rdata_b;

    // List A storage
    smma_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    // List B storage
    smma_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // Load control and merge walk
    smma_core #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW),
        .CW        (CW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .col       (col),
        .row       (row),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col_res   (col_res),
        .row_res   (row_res),
        .value_res (value_res),
        .last      (last),
        .empty_res (empty_res),
        .overflow  (overflow),
        .we_a      (we_a),
        .we_b      (we_b),
        .waddr_a   (waddr_a),
        .waddr_b   (waddr_b),
        .wdata     (wdata),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

endmodule

`default_nettype wire
